// ===== rtl/ehd_pkg.sv =====
// ----------------------------------------------------------------------------
// ehd_pkg
// Shared types, constants and the holiday offset table of the Easter
// holy-days calculator.
// ----------------------------------------------------------------------------
package ehd_pkg;

  localparam int YEAR_W   = 14;
  localparam int OFS_W    = 6;   // days from March 1 to Easter Sunday
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;

  // Computus constants
  localparam int GREG_M_LIMIT  = 451;
  localparam int COMPUTUS_BIAS = 114;
  localparam int MAR1_BASE     = 93;                    // base of March 1
  localparam int EASTER_MAR1   = COMPUTUS_BIAS - MAR1_BASE;
  localparam int EPACT_MOD     = 30;

  // Offsets from Easter Sunday in days
  localparam int OFS_CARN_START = 49;
  localparam int OFS_CARN_END   = 47;
  localparam int OFS_GOOD_FRI   = 2;
  localparam int OFS_ASCENSION  = 39;
  localparam int OFS_WHITSUN    = 49;

  typedef enum logic [2:0] {
    HOL_EASTER     = 3'd0,
    HOL_CARN_START = 3'd1,
    HOL_CARN_END   = 3'd2,
    HOL_GOOD_FRI   = 3'd3,
    HOL_ASCENSION  = 3'd4,
    HOL_WHITSUN    = 3'd5
  } holiday_t;

  // Easter date of one year as days after March 1, plus the leap flag
  typedef struct packed {
    logic [OFS_W-1:0] easter_ofs;
    logic             leap;
  } date_base_t;

  // Signed day offset of a holiday from Easter Sunday
  function automatic logic signed [7:0] hol_offset(input holiday_t hol);
    logic signed [7:0] ofs;
    case (hol)
      HOL_CARN_START: ofs = -8'(OFS_CARN_START);
      HOL_CARN_END:   ofs = -8'(OFS_CARN_END);
      HOL_GOOD_FRI:   ofs = -8'(OFS_GOOD_FRI);
      HOL_ASCENSION:  ofs = 8'(OFS_ASCENSION);
      HOL_WHITSUN:    ofs = 8'(OFS_WHITSUN);
      default:        ofs = 8'sd0;
    endcase
    return ofs;
  endfunction

endpackage

// ===== rtl/easter_holy_days_calculator_core.sv =====
// ----------------------------------------------------------------------------
// easter_holy_days_calculator_core
// Gregorian Easter and dependent holy days for one year per input word.
// ----------------------------------------------------------------------------
// Each accepted year yields six result words in fixed order: Easter, carnival
// start, carnival end, Good Friday, Ascension Day and Whitsuntide, the last
// one flagged. All six words share the single result port, one per handshake;
// the next years are taken and worked on in the computus pipeline while the
// current year is still being delivered. The first result word of a year
// passes the input register, the computus pipeline and the sequencer register.
module easter_holy_days_calculator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ehd_pkg::YEAR_W-1:0]  in_year,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_holiday,
  output logic [ehd_pkg::MONTH_W-1:0] out_month_number,
  output logic [ehd_pkg::DAY_W-1:0]   out_day_of_month,
  output logic                        out_last_result
);
  import ehd_pkg::*;

  logic              v0_r;
  logic [YEAR_W-1:0] year_r;
  logic              adv;
  logic              comp_valid;
  date_base_t        comp_base;
  logic              seq_ready;
  holiday_t          seq_holiday;
  date_base_t        seq_base;

  // Stall the whole front pipe while a finished year waits for the sequencer
  assign adv      = !comp_valid || seq_ready;
  assign in_ready = adv;

  // Register the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      year_r <= in_year;
    end
  end

  ehd_computus u_computus (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v0_r),
    .in_year   (year_r),
    .out_valid (comp_valid),
    .out_base  (comp_base)
  );

  ehd_sequencer u_sequencer (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (comp_valid),
    .up_base     (comp_base),
    .up_ready    (seq_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_holiday (seq_holiday),
    .out_base    (seq_base),
    .out_last    (out_last_result)
  );

  ehd_date u_date (
    .base         (seq_base),
    .holiday      (seq_holiday),
    .month_number (out_month_number),
    .day_of_month (out_day_of_month)
  );

  assign out_holiday = seq_holiday;

endmodule

// ===== rtl/ehd_computus.sv =====
// ----------------------------------------------------------------------------
// ehd_computus
// Six-stage pipeline of the anonymous Gregorian computus. Turns a year into
// the Easter Sunday offset from March 1 and the leap-year flag.
// ----------------------------------------------------------------------------
module ehd_computus (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [ehd_pkg::YEAR_W-1:0] in_year,
  output logic                       out_valid,
  output ehd_pkg::date_base_t        out_base
);
  import ehd_pkg::*;

  logic [5:0] v_r;

  // Stage 1: quotients by 100 and by 19 through reciprocal multiplies
  logic [YEAR_W-1:0] y1_r;
  logic [7:0]        b1_r;
  logic [9:0]        q1_r;
  logic [26:0]       b_prod;
  logic [29:0]       q_prod;

  // Stage 2: remainders and leap flag
  logic [4:0] a2_r;
  logic [7:0] b2_r;
  logic [6:0] c2_r;
  logic       leap2_r;
  logic [4:0] a_nxt;
  logic [6:0] c_nxt;

  // Stage 3: epact sum and weekday sum before reduction
  logic [4:0]  a3_r;
  logic [9:0]  hsum3_r;
  logic [6:0]  lpart3_r;
  logic        leap3_r;
  logic [13:0] f_prod;
  logic [2:0]  f_val;
  logic [7:0]  g_arg;
  logic [15:0] g_prod;
  logic [5:0]  g_val;
  logic [5:0]  d_val;
  logic [9:0]  hsum_nxt;
  logic [6:0]  lpart_nxt;

  // Stage 4: epact modulo 30
  logic [4:0]  a4_r;
  logic [4:0]  h4_r;
  logic [6:0]  lx4_r;
  logic        leap4_r;
  logic [21:0] h_prod;
  logic [5:0]  h_quo;
  logic [4:0]  h_nxt;

  // Stage 5: weekday modulo 7 and correction sum
  logic [4:0]  h5_r;
  logic [2:0]  l5_r;
  logic [8:0]  msum5_r;
  logic        leap5_r;
  logic [12:0] l_prod;
  logic [4:0]  l_quo;
  logic [2:0]  l_nxt;

  // Stage 6: Easter offset from March 1
  date_base_t base6_r;
  logic       m_bit;

  // Advance valid bits with the whole pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  assign b_prod = 27'({13'b0, in_year} * 27'd5243);
  assign q_prod = 30'({16'b0, in_year} * 30'd55189);

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_r <= in_year;
      b1_r <= b_prod[26:19];
      q1_r <= q_prod[29:20];
    end
  end

  assign a_nxt = 5'(y1_r - 14'({4'b0, q1_r} * 14'd19));
  assign c_nxt = 7'(y1_r - 14'({6'b0, b1_r} * 14'd100));

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r    <= a_nxt;
      b2_r    <= b1_r;
      c2_r    <= c_nxt;
      leap2_r <= (y1_r[1:0] == 2'b00) && ((c_nxt != 7'd0) || (b1_r[1:0] == 2'b00));
    end
  end

  // Solar and lunar corrections feed the epact sum
  assign d_val     = b2_r[7:2];
  assign f_prod    = 14'(({6'b0, b2_r} + 14'd8) * 14'd41);
  assign f_val     = f_prod[12:10];
  assign g_arg     = 8'(b2_r - {5'b0, f_val} + 8'd1);
  assign g_prod    = 16'({8'b0, g_arg} * 16'd171);
  assign g_val     = g_prod[14:9];
  assign hsum_nxt  = 10'({5'b0, a2_r} * 10'd19) + {2'b0, b2_r} - {4'b0, d_val}
                   - {4'b0, g_val} + 10'd15;
  assign lpart_nxt = 7'd32 + {4'b0, b2_r[1:0], 1'b0} + {1'b0, c2_r[6:2], 1'b0}
                   - {5'b0, c2_r[1:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      a3_r     <= a2_r;
      hsum3_r  <= hsum_nxt;
      lpart3_r <= lpart_nxt;
      leap3_r  <= leap2_r;
    end
  end

  assign h_prod = 22'({12'b0, hsum3_r} * 22'd2185);
  assign h_quo  = h_prod[21:16];
  assign h_nxt  = 5'(hsum3_r - 10'({4'b0, h_quo} * 10'(EPACT_MOD)));

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_r    <= a3_r;
      h4_r    <= h_nxt;
      lx4_r   <= 7'(lpart3_r - {2'b0, h_nxt});
      leap4_r <= leap3_r;
    end
  end

  assign l_prod = 13'({6'b0, lx4_r} * 13'd37);
  assign l_quo  = l_prod[12:8];
  assign l_nxt  = 3'(lx4_r - 7'({2'b0, l_quo} * 7'd7));

  always_ff @(posedge clk) begin
    if (adv) begin
      h5_r    <= h4_r;
      l5_r    <= l_nxt;
      msum5_r <= 9'({4'b0, a4_r}) + 9'({4'b0, h4_r} * 9'd11) + 9'({6'b0, l_nxt} * 9'd22);
      leap5_r <= leap4_r;
    end
  end

  assign m_bit = (msum5_r >= 9'(GREG_M_LIMIT));

  always_ff @(posedge clk) begin
    if (adv) begin
      base6_r.easter_ofs <= 6'({1'b0, h5_r} + {3'b0, l5_r} + 6'(EASTER_MAR1)
                          - (m_bit ? 6'd7 : 6'd0));
      base6_r.leap       <= leap5_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_base  = base6_r;

endmodule

// ===== rtl/ehd_sequencer.sv =====
// ----------------------------------------------------------------------------
// ehd_sequencer
// Holds one year's Easter date and steps through the six holidays, one
// result word per accepted handshake.
// ----------------------------------------------------------------------------
module ehd_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  ehd_pkg::date_base_t up_base,
  output logic                up_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ehd_pkg::holiday_t   out_holiday,
  output ehd_pkg::date_base_t out_base,
  output logic                out_last
);
  import ehd_pkg::*;

  logic       v_r;
  holiday_t   hol_r;
  date_base_t base_r;

  assign out_last = (hol_r == HOL_WHITSUN);
  assign up_ready = !v_r || (out_ready && out_last);

  // Load a new year after the last word, else advance the holiday
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      hol_r <= HOL_EASTER;
    end else if (up_ready) begin
      v_r   <= up_valid;
      hol_r <= HOL_EASTER;
    end else if (out_ready) begin
      hol_r <= holiday_t'(hol_r + 3'd1);
    end
  end

  // Hold the date of the year in flight
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      base_r <= up_base;
    end
  end

  assign out_valid   = v_r;
  assign out_holiday = hol_r;
  assign out_base    = base_r;

endmodule

// ===== rtl/ehd_date.sv =====
// ----------------------------------------------------------------------------
// ehd_date
// Turns the Easter offset and a holiday into month and day of month.
// ----------------------------------------------------------------------------
module ehd_date (
  input  ehd_pkg::date_base_t         base,
  input  ehd_pkg::holiday_t           holiday,
  output logic [ehd_pkg::MONTH_W-1:0] month_number,
  output logic [ehd_pkg::DAY_W-1:0]   day_of_month
);
  import ehd_pkg::*;

  logic signed [8:0] t_ofs;     // days after March 1, may be negative
  logic signed [8:0] feb_len;
  logic signed [8:0] day_w;

  assign t_ofs   = $signed({3'b000, base.easter_ofs}) + 9'(hol_offset(holiday));
  assign feb_len = 9'sd28 + $signed({8'b0, base.leap});

  // Walk back or forward from March by month boundaries; February's length follows the leap flag
  always_comb begin
    if (t_ofs >= 9'sd92) begin
      month_number = 4'd6;
      day_w        = t_ofs - 9'sd91;
    end else if (t_ofs >= 9'sd61) begin
      month_number = 4'd5;
      day_w        = t_ofs - 9'sd60;
    end else if (t_ofs >= 9'sd31) begin
      month_number = 4'd4;
      day_w        = t_ofs - 9'sd30;
    end else if (t_ofs >= 9'sd0) begin
      month_number = 4'd3;
      day_w        = t_ofs + 9'sd1;
    end else if (t_ofs >= -feb_len) begin
      month_number = 4'd2;
      day_w        = feb_len + t_ofs + 9'sd1;
    end else begin
      month_number = 4'd1;
      day_w        = feb_len + t_ofs + 9'sd32;
    end
  end

  assign day_of_month = day_w[DAY_W-1:0];

endmodule

// ===== rtl/ehd_checker.sv =====
// ----------------------------------------------------------------------------
// ehd_checker
// Port-level checks of the holy-days calculator, bound to the top level.
// ----------------------------------------------------------------------------
module ehd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  out_holiday,
  input logic [ehd_pkg::MONTH_W-1:0] out_month_number,
  input logic [ehd_pkg::DAY_W-1:0]   out_day_of_month,
  input logic                        out_last_result
);
  import ehd_pkg::*;

  // A stalled word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_holiday)
      && $stable(out_month_number) && $stable(out_day_of_month))
    else $error("result word changed while stalled");

  // Last flag marks Whitsuntide only
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_result == (out_holiday == HOL_WHITSUN)))
    else $error("last flag does not match holiday");

  // Holidays of one year follow without a gap, in order
  a_hol_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=>
      out_valid && (out_holiday == 3'($past(out_holiday) + 3'd1)))
    else $error("holiday sequence broken");

  // Easter Sunday lands in March or April
  a_easter_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_holiday == HOL_EASTER) |->
      (out_month_number == 4'd3) || (out_month_number == 4'd4))
    else $error("Easter outside March and April");

endmodule

bind easter_holy_days_calculator_core ehd_checker u_ehd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_holiday      (out_holiday),
  .out_month_number (out_month_number),
  .out_day_of_month (out_day_of_month),
  .out_last_result  (out_last_result)
);

// ===== tb/tb_easter_holy_days_calculator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_easter_holy_days_calculator_core
// Self-checking bench for the Easter holy-days calculator.
// ----------------------------------------------------------------------------
// Years go in on the input channel. For each accepted year the ledger works
// out the six holy-day dates with its own computus and calendar walk, and
// queues them. Every result word is checked against the oldest queued date.
// Traffic runs in phases with no idling, a slow sender, a stalling receiver
// and both sides idling now and then.
// ----------------------------------------------------------------------------

typedef struct {
  ehd_pkg::holiday_t holiday;
  logic [3:0]        month;
  logic [4:0]        day;
  logic              last;
} holy_date_t;

// Predicts the holy days of each accepted year and checks result words
class holy_day_ledger;
  holy_date_t pending_dates[$];
  int         errors;

  function int unsigned month_days(int unsigned yr, int unsigned mon);
    bit leap_yr;
    leap_yr = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mon) inside
      2: return leap_yr ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Work out the six dates of one year and queue them in output order
  function void note_year(logic [ehd_pkg::YEAR_W-1:0] year_word);
    int unsigned yr, a, b, c, d, e, f, g, h, i, k, l, m;
    int unsigned base, easter_mon, sun_mday, sun_yday, rem, mon;
    int          shifted;
    holy_date_t  hd;
    ehd_pkg::holiday_t order[6];
    int          shift[6];
    order = '{ehd_pkg::HOL_EASTER, ehd_pkg::HOL_CARN_START, ehd_pkg::HOL_CARN_END,
              ehd_pkg::HOL_GOOD_FRI, ehd_pkg::HOL_ASCENSION, ehd_pkg::HOL_WHITSUN};
    shift = '{0, -ehd_pkg::OFS_CARN_START, -ehd_pkg::OFS_CARN_END,
              -ehd_pkg::OFS_GOOD_FRI, ehd_pkg::OFS_ASCENSION, ehd_pkg::OFS_WHITSUN};
    yr = year_word;
    // anonymous Gregorian computus
    a = yr % 19;
    b = yr / 100;
    c = yr % 100;
    d = b / 4;
    e = b % 4;
    f = (b + 8) / 25;
    g = (b - f + 1) / 3;
    h = (19 * a + b - d - g + 15) % 30;
    i = c / 4;
    k = c % 4;
    l = (32 + 2 * e + 2 * i - h - k) % 7;
    m = (a + 11 * h + 22 * l) / 451;
    base = h + l + 114 - 7 * m;
    easter_mon = base / 31;
    sun_mday = base % 31 + 1;
    // day of the year of Easter Sunday
    sun_yday = sun_mday;
    for (int unsigned mm = 1; mm < easter_mon && mm <= 12; mm++)
      sun_yday += month_days(yr, mm);
    for (int n = 0; n < 6; n++) begin
      if (n == 0) begin
        mon = easter_mon;
        rem = sun_mday;
      end else begin
        shifted = int'(sun_yday) + shift[n];
        rem = (shifted < 1) ? 1 : shifted;
        mon = 1;
        while (mon < 12 && rem > month_days(yr, mon)) begin
          rem -= month_days(yr, mon);
          mon++;
        end
      end
      hd.holiday = order[n];
      hd.month   = mon[3:0];
      hd.day     = rem[4:0];
      hd.last    = (order[n] == ehd_pkg::HOL_WHITSUN);
      pending_dates.push_back(hd);
    end
  endfunction

  function void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  // Compare one result word with the oldest queued date
  function void check_date(logic [2:0] hol, logic [3:0] mon, logic [4:0] day,
                           logic last);
    holy_date_t exp_date;
    if (pending_dates.size() == 0) begin
      flag_error($sformatf("unexpected word holiday=%0d month=%0d day=%0d last=%0b",
                           hol, mon, day, last));
      return;
    end
    exp_date = pending_dates.pop_front();
    if (hol !== exp_date.holiday || mon !== exp_date.month ||
        day !== exp_date.day || last !== exp_date.last)
      flag_error($sformatf({"expected holiday=%0d month=%0d day=%0d last=%0b, ",
                            "got holiday=%0d month=%0d day=%0d last=%0b"},
                           exp_date.holiday, exp_date.month, exp_date.day,
                           exp_date.last, hol, mon, day, last));
  endfunction
endclass

module tb_easter_holy_days_calculator_core;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 95;

  typedef logic [ehd_pkg::YEAR_W-1:0] year_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [ehd_pkg::YEAR_W-1:0]  in_year = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [2:0]                  out_holiday;
  logic [ehd_pkg::MONTH_W-1:0] out_month_number;
  logic [ehd_pkg::DAY_W-1:0]   out_day_of_month;
  logic                        out_last_result;

  int             gap_pct = 0;
  int             stall_pct = 0;
  int             quiet_cycles = 0;
  holy_day_ledger ledger = new();

  easter_holy_days_calculator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_year          (in_year),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_holiday      (out_holiday),
    .out_month_number (out_month_number),
    .out_day_of_month (out_day_of_month),
    .out_last_result  (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Note accepted years, check accepted result words
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      ledger.note_year(in_year);
    if (rst_n && out_valid && out_ready)
      ledger.check_date(out_holiday, out_month_number, out_day_of_month,
                        out_last_result);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one year, idling the sender beforehand at random
  task automatic send_year(input logic [ehd_pkg::YEAR_W-1:0] yr);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_year  <= yr;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_random_years(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0)
        send_year(year_t'($urandom_range(1583, 2600)));
      else
        send_year(year_t'($urandom_range(0, (1 << ehd_pkg::YEAR_W) - 1)));
    end
  endtask

  initial begin
    int directed[$];
    // extremes, leap rules, earliest and latest Easter, computus corrections
    directed = '{0, 1, 4, 100, 400, 1583, 16383, 8191, 10922, 5461,
                 1900, 2000, 2100, 2024, 2008, 1818, 2285, 1943, 2038,
                 1954, 1981, 2049, 2076, 2019, 3000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no idling
    foreach (directed[n]) send_year(year_t'(directed[n]));
    send_random_years(RANDOM_PER_PHASE);
    // slow sender
    gap_pct = 82;
    send_random_years(RANDOM_PER_PHASE);
    // stalling receiver
    gap_pct   = 0;
    stall_pct = 82;
    send_random_years(RANDOM_PER_PHASE);
    // both sides idle now and then
    gap_pct   = 18;
    stall_pct = 18;
    send_random_years(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (ledger.pending_dates.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_dates.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
